// ===== hdl/sha_pkg.sv =====
package sha_pkg;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_LOAD,
        t_ST_ROUND,
        t_ST_FOLD,
        t_ST_PAD,
        t_ST_EMIT
    } t_state;

    typedef struct packed {
        logic       put_byte;
        logic [7:0] put_value;
        logic       add_bits;
        logic       load_start;
        logic       load_step;
        logic       round_step;
        logic       fold;
        logic       restart;
    } t_cmd;

    typedef struct packed {
        logic       fill_full;
        logic [5:0] fill_count;
        logic [5:0] round_count;
        logic       load_done;
        logic       round_done;
        logic [7:0] len_byte;
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== hdl/sha_if.sv =====
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha256_message_hasher_unit.sv =====
// one request per cycle while a block fills; a full block stalls input while it is compressed:
// 16 buffer word loads, 64 rounds of the single round unit, one fold
// a closing request pads byte by byte and may compress one or two blocks
// the eight digest words then leave one per cycle while the sink accepts them, an output register decouples the sink
// synchronous active-low reset restores the initial hash value and empties the block
module sha256_message_hasher_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    i_req,
    sha_out_if.source o_rsp
);
    import sha_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [2:0]  word_sel;
    logic [31:0] hash_word;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_status   (status),
        .i_hash_word(hash_word),
        .o_cmd      (cmd),
        .o_word_sel (word_sel)
    );

    sha_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_word_sel (word_sel),
        .o_status   (status),
        .o_hash_word(hash_word)
    );
endmodule

// ===== hdl/sha_datapath.sv =====
module sha_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sha_pkg::t_cmd   i_cmd,
    input  logic [2:0]      i_word_sel,
    output sha_pkg::t_status o_status,
    output logic [31:0]     o_hash_word
);
    import sha_pkg::*;

    logic [31:0] r_buf [16];
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [3:0]  r_ld;
    logic [31:0] r_rd;
    logic        r_rd_ok;
    logic [2:0]  len_sel;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    logic [31:0] w_cur, w_new, s0, s1, t1, t2, ch, mj, x, y;

    always_comb begin
        w_cur = r_w[0];
        x = r_w[1];
        y = r_w[14];
        s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
        s1 = ror(y, 17) ^ ror(y, 19) ^ (y >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25)) + ch
            + ROUND_K[r_rnd] + w_cur;
        t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22)) + mj;
        n_fill = r_fill + 6'd1;
    end

    // buffer memory, one byte lane written, one word read per load cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_cmd.put_value;
        end
        r_rd <= r_buf[i_cmd.load_start ? 4'd0 : r_ld];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_bits <= '0;
            r_ld <= '0;
            r_rd_ok <= 1'b0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV_WORDS[i];
        end else begin
            if (i_cmd.put_byte) r_fill <= n_fill;
            if (i_cmd.add_bits) r_bits <= r_bits + 64'd8;
            if (i_cmd.load_start) begin
                r_ld <= 4'd1;
                r_rd_ok <= 1'b1;
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end else if (i_cmd.load_step) begin
                r_ld <= r_ld + 4'd1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= r_rd;
                r_rd_ok <= (r_ld != 4'd0);
            end
            if (i_cmd.round_step) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (i_cmd.restart) begin
                r_fill <= '0;
                r_bits <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= IV_WORDS[i];
            end
        end
    end

    always_comb len_sel = 3'd7 - (r_fill[2:0]);

    always_comb begin
        o_status.fill_full   = (r_fill == 6'd63) && i_cmd.put_byte;
        o_status.fill_count  = r_fill;
        o_status.round_count = r_rnd;
        o_status.load_done   = (r_ld == 4'd0) && r_rd_ok;
        o_status.round_done  = (r_rnd == 6'd63);
        o_status.len_byte    = r_bits[{len_sel, 3'b000} +: 8];
        o_hash_word          = r_h[i_word_sel];
    end
endmodule

// ===== hdl/sha_ctrl.sv =====
module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sha_in_if.sink           i_req,
    sha_out_if.source        o_rsp,
    input  sha_pkg::t_status i_status,
    input  logic [31:0]      i_hash_word,
    output sha_pkg::t_cmd    o_cmd,
    output logic [2:0]       o_word_sel
);
    import sha_pkg::*;

    t_state     r_state, n_state;
    logic       r_end, n_end;
    logic       r_pad_first, n_pad_first;
    logic       r_len_blk, n_len_blk;
    logic [2:0] r_idx, n_idx;
    logic       r_ovalid, n_ovalid;
    logic [31:0] r_oword, n_oword;
    logic [2:0] r_oidx, n_oidx;
    logic       r_olast, n_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
            r_end <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_blk <= 1'b0;
            r_idx <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end <= n_end;
            r_pad_first <= n_pad_first;
            r_len_blk <= n_len_blk;
            r_idx <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oword <= n_oword;
        r_oidx <= n_oidx;
        r_olast <= n_olast;
    end

    logic accept, out_free;

    always_comb begin
        n_state = r_state;
        n_end = r_end;
        n_pad_first = r_pad_first;
        n_len_blk = r_len_blk;
        n_idx = r_idx;
        n_ovalid = r_ovalid;
        n_oword = r_oword;
        n_oidx = r_oidx;
        n_olast = r_olast;
        o_cmd = '0;
        out_free = !r_ovalid || o_rsp.ready;
        i_req.ready = (r_state == t_ST_IDLE);
        accept = i_req.valid && i_req.ready;
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        unique case (r_state)
            t_ST_IDLE: begin
                if (accept) begin
                    n_end = i_req.message_end;
                    n_pad_first = 1'b1;
                    if (i_req.byte_present) begin
                        o_cmd.put_byte = 1'b1;
                        o_cmd.put_value = i_req.data_byte;
                        o_cmd.add_bits = 1'b1;
                        if (i_status.fill_full) n_state = t_ST_LOAD;
                        else if (i_req.message_end) n_state = t_ST_PAD;
                    end else if (i_req.message_end) begin
                        n_state = t_ST_PAD;
                    end
                    if (i_status.fill_full) o_cmd.load_start = 1'b1;
                end
            end
            t_ST_LOAD: begin
                o_cmd.load_step = 1'b1;
                if (i_status.load_done) n_state = t_ST_ROUND;
            end
            t_ST_ROUND: begin
                o_cmd.round_step = 1'b1;
                if (i_status.round_done) n_state = t_ST_FOLD;
            end
            t_ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!r_end) n_state = t_ST_IDLE;
                else if (r_pad_first) n_state = t_ST_PAD;
                else if (!r_len_blk) begin
                    // length goes into a block of its own
                    n_len_blk = 1'b1;
                    n_state = t_ST_PAD;
                end else begin
                    n_state = t_ST_EMIT;
                    n_idx = '0;
                end
            end
            t_ST_PAD: begin
                o_cmd.put_byte = 1'b1;
                n_pad_first = 1'b0;
                if (r_pad_first) begin
                    o_cmd.put_value = PAD_BYTE;
                    n_len_blk = (i_status.fill_count < LENGTH_POS);
                end else if (r_len_blk && i_status.fill_count >= LENGTH_POS) begin
                    o_cmd.put_value = i_status.len_byte;
                end else begin
                    o_cmd.put_value = 8'h00;
                end
                if (i_status.fill_full) begin
                    o_cmd.load_start = 1'b1;
                    n_state = t_ST_LOAD;
                end
            end
            t_ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oword = i_hash_word;
                    n_oidx = r_idx;
                    n_olast = (r_idx == 3'd7);
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_end = 1'b0;
                        n_state = t_ST_IDLE;
                    end
                end
            end
            default: n_state = t_ST_IDLE;
        endcase
        o_word_sel = r_idx;
        o_rsp.valid = r_ovalid;
        o_rsp.digest_word = r_oword;
        o_rsp.word_index = r_oidx;
        o_rsp.last_word = r_olast;
    end
endmodule
